FILE: sv/dfhe_pkg.sv
package dfhe_pkg;

	// configuration register
	localparam int unsigned CAP_W       = 21;
	localparam logic [CAP_W-1:0] CAP_RESET = 21'h100000;

	// token assembly widths
	localparam int unsigned TOK_W       = 34;   // header + longest match
	localparam int unsigned TOK_CNT_W   = 6;
	localparam int unsigned PEND_W      = 7;    // fewer than 8 bits wait between tokens
	localparam int unsigned PCNT_W      = 3;
	localparam int unsigned MERGE_W     = 41;   // pending + token
	localparam int unsigned ENTRY_BYTES = 5;
	localparam int unsigned NBYTES_W    = 3;

	// decoupling queue
	localparam int unsigned QUEUE_DEPTH = 4;

	// fixed huffman code constants
	localparam logic [8:0] LIT_LOW_OFS  = 9'h030;
	localparam logic [8:0] LEN_HIGH_OFS = 9'h0C0;
	localparam logic [7:0] LIT_LOW_MAX  = 8'd143;
	localparam logic [4:0] LEN_LOW_MAX  = 5'd22;   // symbol 279
	localparam logic [8:0] LEN_MIN      = 9'd3;
	localparam logic [8:0] LEN_MAX      = 9'd258;
	localparam logic [15:0] DIST_MAX    = 16'd32768;
	localparam logic [2:0] HDR_BITS     = 3'b011; // bfinal, btype fixed

	typedef enum logic [1:0] {
		KIND_LITERAL = 2'd0,
		KIND_MATCH   = 2'd1,
		KIND_END     = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	localparam logic [8:0] LEN_BASE [0:28] = '{
		9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
		9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83,
		9'd99, 9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
	};
	localparam logic [2:0] LEN_XBITS [0:28] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd0
	};
	localparam logic [15:0] DIST_BASE [0:29] = '{
		16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
		16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385,
		16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097,
		16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577
	};
	localparam logic [3:0] DIST_XBITS [0:29] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
		4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
		4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
	};

	// one queue entry: bytes completed by one token
	typedef struct packed {
		logic [ENTRY_BYTES-1:0][7:0] bytes;
		logic [NBYTES_W-1:0]         nbytes;
		logic                        done;
	} tok_entry_t;

	function automatic logic [4:0] len_code(input logic [8:0] len);
		logic [4:0] lc;
		lc = '0;
		for (int i = 1; i < 29; i++) begin
			if (len >= LEN_BASE[i]) lc = 5'(i);
		end
		return lc;
	endfunction

	function automatic logic [4:0] dist_code(input logic [15:0] distance);
		logic [4:0] dc;
		dc = '0;
		for (int i = 1; i < 30; i++) begin
			if (distance >= DIST_BASE[i]) dc = 5'(i);
		end
		return dc;
	endfunction

	function automatic logic [8:0] rev9(input logic [8:0] v);
		logic [8:0] r;
		for (int i = 0; i < 9; i++) r[i] = v[8-i];
		return r;
	endfunction

	function automatic logic [4:0] rev5(input logic [4:0] v);
		logic [4:0] r;
		for (int i = 0; i < 5; i++) r[i] = v[4-i];
		return r;
	endfunction

endpackage

FILE: sv/deflate_fixed_huffman_encoder_unit.sv
// channel      dir  handshake              payload
// s_axis       in   tvalid/tready          tuser kind, tdata literal/length/distance
// m_axis       out  tvalid/tready          tuser flags, tdata byte/count, tlast
// cfg          in   cfg_valid/cfg_ready    cfg_data output capacity in bytes
//
// a token is taken every cycle while the token queue has room; it passes one
// register stage for code lookup and is merged with the pending bits on entry
// to the queue. the byte sequencer sends one result per cycle while the receiver
// takes them, so a token gives at most max(1, bytes it completes) results (one to five).
// arst_n clears all control state; the capacity returns to 1048576 bytes.
// either side may stall; the queue and the output register keep both running.
module deflate_fixed_huffman_encoder_unit #(
	parameter int unsigned QUEUE_DEPTH = dfhe_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // literal[7:0], match_length[16:8],
	                                   // match_distance[32:17], zero[39:33]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_byte[7:0], bytes_written[28:8], zero[31:29]
	output logic        m_axis_tlast,
	output logic [2:0]  m_axis_tuser,  // byte_valid[0], block_done[1], overflow_error[2]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [20:0] cfg_data
);

	logic [dfhe_pkg::CAP_W-1:0] cap_q;
	logic                       q_full, q_push, q_pop, head_valid;
	dfhe_pkg::tok_entry_t       q_entry, head;

	// capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= dfhe_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	dfhe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (q_entry)
	);

	dfhe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_entry   (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	dfhe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cap           (cap_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// a byte result never counts past the capacity
	a_cap_respected: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[28:8] <= cap_q)
		else $error("byte count beyond capacity");

	// block end closes the token's results
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("block_done without tlast");

	// a status result is the only result of its token and carries no byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
		else $error("malformed status result");

	// the front never writes into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue overrun");

endmodule

FILE: sv/dfhe_front.sv
module dfhe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [39:0]         s_axis_tdata,
	input  logic [1:0]          s_axis_tuser,
	input  logic                q_full,
	output logic                q_push,
	output dfhe_pkg::tok_entry_t q_entry
);

	dfhe_pkg::kind_t kind;
	logic [7:0]  lit;
	logic [8:0]  len_in, len_c;
	logic [15:0] dist_in, dist_c;
	logic [4:0]  lc, dc;
	logic [2:0]  lx;
	logic [3:0]  dx;
	logic [4:0]  lext;
	logic [12:0] dext;
	logic [8:0]  sym_code, sym_rev;
	logic [3:0]  sym_n;
	logic        is_match;
	logic [1:0]  hdr_n;
	logic [2:0]  hdr;
	logic [13:0] len_part;
	logic [3:0]  len_n;
	logic [17:0] dist_part;
	logic [4:0]  dist_n;
	logic [dfhe_pkg::TOK_W-1:0]     tok;
	logic [dfhe_pkg::TOK_CNT_W-1:0] tok_cnt;
	logic        accept;

	logic                            valid_s1;
	logic [dfhe_pkg::TOK_W-1:0]      tok_s1;
	logic [dfhe_pkg::TOK_CNT_W-1:0]  cnt_s1;
	logic                            done_s1;
	logic                            block_start_q;

	logic [dfhe_pkg::PEND_W-1:0]     pend_q;
	logic [dfhe_pkg::PCNT_W-1:0]     pcnt_q;
	logic [dfhe_pkg::MERGE_W-1:0]    merged;
	logic [dfhe_pkg::TOK_CNT_W-1:0]  mcount, mcount_up;
	logic [dfhe_pkg::NBYTES_W-1:0]   nbytes;
	logic [dfhe_pkg::MERGE_W-1:0]    rest;

	// field unpacking and range clamps
	assign kind    = dfhe_pkg::kind_t'(s_axis_tuser);
	assign lit     = s_axis_tdata[7:0];
	assign len_in  = s_axis_tdata[16:8];
	assign dist_in = s_axis_tdata[32:17];

	always_comb begin
		if (len_in < dfhe_pkg::LEN_MIN) len_c = dfhe_pkg::LEN_MIN;
		else if (len_in > dfhe_pkg::LEN_MAX) len_c = dfhe_pkg::LEN_MAX;
		else len_c = len_in;
		if (dist_in == 16'd0) dist_c = 16'd1;
		else if (dist_in > dfhe_pkg::DIST_MAX) dist_c = dfhe_pkg::DIST_MAX;
		else dist_c = dist_in;
	end

	// length and distance codes with extra bits
	assign lc   = dfhe_pkg::len_code(len_c);
	assign lx   = dfhe_pkg::LEN_XBITS[lc];
	assign lext = 5'(len_c - dfhe_pkg::LEN_BASE[lc]);
	assign dc   = dfhe_pkg::dist_code(dist_c);
	assign dx   = dfhe_pkg::DIST_XBITS[dc];
	assign dext = 13'(dist_c - dfhe_pkg::DIST_BASE[dc]);
	assign is_match = (kind == dfhe_pkg::KIND_MATCH);

	// literal/length symbol code
	always_comb begin
		unique case (kind)
			dfhe_pkg::KIND_LITERAL: begin
				if (lit <= dfhe_pkg::LIT_LOW_MAX) begin
					sym_code = 9'(lit) + dfhe_pkg::LIT_LOW_OFS;
					sym_n    = 4'd8;
				end else begin
					sym_code = {1'b1, lit};
					sym_n    = 4'd9;
				end
			end
			dfhe_pkg::KIND_MATCH: begin
				if (lc <= dfhe_pkg::LEN_LOW_MAX) begin
					sym_code = 9'(lc) + 9'd1;
					sym_n    = 4'd7;
				end else begin
					sym_code = dfhe_pkg::LEN_HIGH_OFS + 9'(lc) - 9'(dfhe_pkg::LEN_LOW_MAX)
						- 9'd1;
					sym_n    = 4'd8;
				end
			end
			dfhe_pkg::KIND_END: begin
				sym_code = '0;
				sym_n    = 4'd7;
			end
			default: begin
				sym_code = '0;
				sym_n    = 4'd0;
			end
		endcase
	end

	assign sym_rev = dfhe_pkg::rev9(sym_code) >> (4'd9 - sym_n);

	// token bit string, first bit in bit 0
	always_comb begin
		hdr_n     = (block_start_q && kind != dfhe_pkg::KIND_NONE) ? 2'd3 : 2'd0;
		hdr       = (hdr_n != 2'd0) ? dfhe_pkg::HDR_BITS : 3'b000;
		len_part  = 14'(sym_rev) | ((is_match ? 14'(lext) : 14'd0) << sym_n);
		len_n     = sym_n + (is_match ? 4'(lx) : 4'd0);
		dist_part = is_match ? {dext, dfhe_pkg::rev5(dc)} : 18'd0;
		dist_n    = is_match ? 5'd5 + 5'(dx) : 5'd0;
		tok       = dfhe_pkg::TOK_W'(hdr)
			| (dfhe_pkg::TOK_W'(len_part) << hdr_n)
			| (dfhe_pkg::TOK_W'(dist_part) << (6'(hdr_n) + 6'(len_n)));
		tok_cnt   = dfhe_pkg::TOK_CNT_W'(hdr_n) + dfhe_pkg::TOK_CNT_W'(len_n)
			+ dfhe_pkg::TOK_CNT_W'(dist_n);
	end

	// stage 1 handshake
	assign q_push        = valid_s1 && !q_full;
	assign s_axis_tready = !valid_s1 || !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			block_start_q <= 1'b1;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (kind == dfhe_pkg::KIND_END) block_start_q <= 1'b1;
				else if (kind != dfhe_pkg::KIND_NONE) block_start_q <= 1'b0;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1  <= tok;
			cnt_s1  <= tok_cnt;
			done_s1 <= (kind == dfhe_pkg::KIND_END);
		end
	end

	// merge with pending bits and cut whole bytes
	always_comb begin
		merged    = dfhe_pkg::MERGE_W'(pend_q) | (dfhe_pkg::MERGE_W'(tok_s1) << pcnt_q);
		mcount    = dfhe_pkg::TOK_CNT_W'(pcnt_q) + cnt_s1;
		mcount_up = mcount + dfhe_pkg::TOK_CNT_W'(7);
		nbytes    = done_s1 ? dfhe_pkg::NBYTES_W'(mcount_up >> 3)
			: dfhe_pkg::NBYTES_W'(mcount >> 3);
		rest      = merged >> {nbytes, 3'b000};
		q_entry.bytes  = merged[dfhe_pkg::ENTRY_BYTES*8-1:0];
		q_entry.nbytes = nbytes;
		q_entry.done   = done_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= '0;
		end else if (q_push) begin
			if (done_s1) begin
				pend_q <= '0;
				pcnt_q <= '0;
			end else begin
				pend_q <= rest[dfhe_pkg::PEND_W-1:0];
				pcnt_q <= mcount[dfhe_pkg::PCNT_W-1:0];
			end
		end
	end

endmodule

FILE: sv/dfhe_queue.sv
module dfhe_queue #(
	parameter int unsigned DEPTH = dfhe_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dfhe_pkg::tok_entry_t wr_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output dfhe_pkg::tok_entry_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dfhe_pkg::tok_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: sv/dfhe_back.sv
module dfhe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dfhe_pkg::CAP_W-1:0]    cap,
	input  logic                          head_valid,
	input  dfhe_pkg::tok_entry_t          head,
	output logic                          pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [31:0]                   m_axis_tdata,
	output logic                          m_axis_tlast,
	output logic [2:0]                    m_axis_tuser
);

	logic [dfhe_pkg::NBYTES_W-1:0] idx_q;
	logic [dfhe_pkg::CAP_W-1:0]    pos_q, pos_inc, res_pos;
	logic                          ovf_q, res_ovf;
	logic                          fire, is_status, final_byte, cut, fin;
	logic [7:0]                    res_byte;
	logic                          res_bv, res_done;

	logic                          tvalid_q;
	logic [7:0]                    byte_q;
	logic [dfhe_pkg::CAP_W-1:0]    pos_out_q;
	logic                          bv_q, last_q, done_q, ovf_out_q;

	assign fire = head_valid && (!tvalid_q || m_axis_tready);

	// per byte decision: emit, cut short at capacity, or status only
	always_comb begin
		is_status  = (head.nbytes == '0) || (pos_q >= cap);
		pos_inc    = pos_q + 1'b1;
		final_byte = (idx_q == head.nbytes - 1'b1);
		cut        = !final_byte && (pos_inc >= cap);
		if (is_status) begin
			fin      = 1'b1;
			res_byte = '0;
			res_bv   = 1'b0;
			res_ovf  = ovf_q || (head.nbytes != '0);
			res_pos  = pos_q;
		end else begin
			fin      = final_byte || cut;
			res_byte = head.bytes[idx_q];
			res_bv   = 1'b1;
			res_ovf  = ovf_q || cut;
			res_pos  = pos_inc;
		end
		res_done = fin && head.done;
		pop      = fire && fin;
	end

	// block bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (fire) begin
			idx_q <= fin ? '0 : idx_q + 1'b1;
			if (res_done) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				pos_q <= res_pos;
				ovf_q <= res_ovf;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (fire) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q    <= res_byte;
			pos_out_q <= res_pos;
			bv_q      <= res_bv;
			last_q    <= fin;
			done_q    <= res_done;
			ovf_out_q <= res_ovf;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = {3'b000, pos_out_q, byte_q};
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = {ovf_out_q, done_q, bv_q};

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned CYCLE_LIMIT = 400000;

	// one result transaction of the encoder
	typedef struct {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        last;
		logic        block_done;
		logic        overflow_error;
		logic [20:0] bytes_written;
	} enc_result_t;

	// fixed-huffman bit packer and the queue of bytes it predicts
	class deflate_scoreboard;
		logic [20:0] capacity = dfhe_pkg::CAP_RESET;
		logic [31:0] bit_acc = '0;
		int unsigned bit_cnt = 0;
		logic [20:0] byte_pos = '0;
		logic        ovf = 1'b0;
		logic        hdr_due = 1'b1;
		enc_result_t token_bytes[$];
		enc_result_t awaited_bytes[$];
		int          errors = 0;

		function logic [31:0] mirror(logic [31:0] v, int n);
			logic [31:0] r;
			r = '0;
			for (int i = 0; i < n; i++) begin
				r = (r << 1) | v[0];
				v = v >> 1;
			end
			return r;
		endfunction

		// length and distance tables in closed form
		function int lcode_xbits(int lc);
			return (lc < 8 || lc == 28) ? 0 : lc / 4 - 1;
		endfunction

		function int lcode_base(int lc);
			if (lc < 8) return lc + 3;
			if (lc == 28) return 258;
			return ((4 + lc % 4) << lcode_xbits(lc)) + 3;
		endfunction

		function int dcode_xbits(int dc);
			return (dc < 4) ? 0 : dc / 2 - 1;
		endfunction

		function int dcode_base(int dc);
			if (dc < 4) return dc + 1;
			return (1 << (dc / 2)) + 1 + ((dc % 2) << (dc / 2 - 1));
		endfunction

		function void emit(logic [7:0] b);
			enc_result_t r;
			if (byte_pos >= capacity) begin
				ovf = 1'b1;
				return;
			end
			byte_pos = byte_pos + 21'd1;
			r.out_byte = b;
			r.byte_valid = 1'b1;
			r.last = 1'b0;
			r.block_done = 1'b0;
			r.overflow_error = ovf;
			r.bytes_written = byte_pos;
			token_bytes.push_back(r);
		endfunction

		function void put_bits(logic [31:0] v, int n);
			v = v & ((32'd1 << n) - 32'd1);
			bit_acc = bit_acc | (v << bit_cnt);
			bit_cnt += n;
			while (bit_cnt >= 8) begin
				emit(bit_acc[7:0]);
				bit_acc = bit_acc >> 8;
				bit_cnt -= 8;
			end
		endfunction

		function void put_symbol(int sym);
			if (sym <= 143) put_bits(mirror(32'h30 + sym, 8), 8);
			else if (sym <= 255) put_bits(mirror(32'h190 + sym - 144, 9), 9);
			else if (sym <= 279) put_bits(mirror(sym - 256, 7), 7);
			else put_bits(mirror(32'hC0 + sym - 280, 8), 8);
		endfunction

		// predict the results of one accepted token
		function void encode_token(dfhe_pkg::kind_t kind, logic [7:0] lit, logic [8:0] len_in,
				logic [15:0] span_in);
			int len;
			int span;
			int lc;
			int dc;
			logic done;
			enc_result_t r;
			token_bytes.delete();
			done = 1'b0;
			len = len_in;
			span = span_in;
			if (kind != dfhe_pkg::KIND_NONE) begin
				if (hdr_due) begin
					put_bits(1, 1);
					put_bits(1, 2);
					hdr_due = 1'b0;
				end
				case (kind)
					dfhe_pkg::KIND_LITERAL: put_symbol(lit);
					dfhe_pkg::KIND_MATCH: begin
						if (len < 3) len = 3;
						if (len > 258) len = 258;
						if (span < 1) span = 1;
						if (span > 32768) span = 32768;
						lc = 0;
						while (lc < 28 && len >= lcode_base(lc + 1)) lc++;
						put_symbol(257 + lc);
						if (lcode_xbits(lc) > 0) put_bits(len - lcode_base(lc), lcode_xbits(lc));
						dc = 0;
						while (dc < 29 && span >= dcode_base(dc + 1)) dc++;
						put_bits(mirror(dc, 5), 5);
						if (dcode_xbits(dc) > 0) put_bits(span - dcode_base(dc), dcode_xbits(dc));
					end
					dfhe_pkg::KIND_END: begin
						put_symbol(256);
						if (bit_cnt > 0) emit(bit_acc[7:0]);
						bit_acc = '0;
						bit_cnt = 0;
						done = 1'b1;
					end
					default: ;
				endcase
			end
			// status-only transaction when no byte came out
			if (token_bytes.size() == 0) begin
				r.out_byte = '0;
				r.byte_valid = 1'b0;
				r.bytes_written = byte_pos;
				token_bytes.push_back(r);
			end
			r = token_bytes.pop_back();
			r.last = 1'b1;
			r.block_done = done;
			r.overflow_error = ovf;
			token_bytes.push_back(r);
			foreach (token_bytes[i]) awaited_bytes.push_back(token_bytes[i]);
			if (done) begin
				byte_pos = '0;
				ovf = 1'b0;
				hdr_due = 1'b1;
			end
		endfunction

		function void compare(string field, logic [20:0] want, logic [20:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check(enc_result_t got);
			enc_result_t want;
			if (awaited_bytes.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual byte %0h",
					$time, got.out_byte);
				errors++;
				return;
			end
			want = awaited_bytes.pop_front();
			compare("out_byte", want.out_byte, got.out_byte);
			compare("byte_valid", want.byte_valid, got.byte_valid);
			compare("last", want.last, got.last);
			compare("block_done", want.block_done, got.block_done);
			compare("overflow_error", want.overflow_error, got.overflow_error);
			compare("bytes_written", want.bytes_written, got.bytes_written);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [2:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [20:0] cfg_data;

	deflate_scoreboard sb = new();
	logic        quiet = 1'b0;
	int unsigned cycles = 0;

	deflate_fixed_huffman_encoder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// output monitor
	always @(posedge clk) begin
		enc_result_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			r.out_byte = m_axis_tdata[7:0];
			r.bytes_written = m_axis_tdata[28:8];
			r.byte_valid = m_axis_tuser[0];
			r.block_done = m_axis_tuser[1];
			r.overflow_error = m_axis_tuser[2];
			r.last = m_axis_tlast;
			sb.check(r);
		end
	end

	// receiver with random stalls
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = quiet ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// one token transaction, called and returning at a falling edge
	task automatic send_token(dfhe_pkg::kind_t kind, logic [7:0] lit, logic [8:0] len,
			logic [15:0] span);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {7'd0, span, len, lit};
		do @(posedge clk); while (!s_axis_tready);
		sb.encode_token(kind, lit, len, span);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.awaited_bytes.size() != 0) @(negedge clk);
	endtask

	// capacity change only once the encoder has gone quiet
	task automatic write_capacity(logic [20:0] value);
		wait_drained();
		repeat (16) @(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.capacity = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_token();
		int pick;
		int w;
		logic [8:0] len;
		logic [15:0] span;
		pick = $urandom_range(0, 99);
		w = $urandom_range(0, 15);
		span = (w == 15) ? 16'd32768 : 16'($urandom_range(1 << w, (2 << w) - 1));
		len = $urandom_range(0, 1) ? 9'($urandom_range(3, 10)) : 9'($urandom_range(3, 258));
		if (pick < 45) begin
			send_token(dfhe_pkg::KIND_LITERAL, 8'($urandom_range(0, 255)), 9'($urandom),
				16'($urandom));
		end else if (pick < 85) begin
			send_token(dfhe_pkg::KIND_MATCH, 8'($urandom), len, span);
		end else if (pick < 92) begin
			send_token(dfhe_pkg::KIND_NONE, 8'($urandom), 9'($urandom), 16'($urandom));
		end else begin
			// clamped length or distance
			len = $urandom_range(0, 1) ? 9'($urandom_range(0, 2)) : 9'($urandom_range(259, 511));
			span = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(32769, 65535));
			send_token(dfhe_pkg::KIND_MATCH, 8'($urandom), len, span);
		end
	endtask

	// blocks of random tokens, most of them closed by an end token
	task automatic random_blocks(int count);
		int sent;
		int n;
		sent = 0;
		while (sent < count) begin
			quiet = ($urandom_range(0, 4) == 0);
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				random_token();
				sent++;
			end
			if ($urandom_range(0, 9) != 0) begin
				send_token(dfhe_pkg::KIND_END, 8'($urandom), 9'($urandom), 16'($urandom));
				sent++;
			end
		end
		quiet = 1'b0;
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = dfhe_pkg::KIND_LITERAL;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: code boundaries, table extremes, clamping, ignored kind
		send_token(dfhe_pkg::KIND_NONE, 8'hFF, 9'h1FF, 16'hFFFF);
		send_token(dfhe_pkg::KIND_LITERAL, 8'd0, 9'd0, 16'd0);
		send_token(dfhe_pkg::KIND_LITERAL, 8'd143, 9'd0, 16'd0);
		send_token(dfhe_pkg::KIND_LITERAL, 8'd144, 9'd0, 16'd0);
		send_token(dfhe_pkg::KIND_LITERAL, 8'd255, 9'd0, 16'd0);
		send_token(dfhe_pkg::KIND_MATCH, 8'd0, 9'd3, 16'd1);
		send_token(dfhe_pkg::KIND_MATCH, 8'd0, 9'd10, 16'd4);
		send_token(dfhe_pkg::KIND_MATCH, 8'd0, 9'd11, 16'd5);
		send_token(dfhe_pkg::KIND_MATCH, 8'd0, 9'd114, 16'd24576);
		send_token(dfhe_pkg::KIND_MATCH, 8'd0, 9'd257, 16'd24577);
		send_token(dfhe_pkg::KIND_MATCH, 8'd0, 9'd258, 16'd32768);
		send_token(dfhe_pkg::KIND_MATCH, 8'd0, 9'd0, 16'd0);
		send_token(dfhe_pkg::KIND_MATCH, 8'hFF, 9'h1FF, 16'hFFFF);
		send_token(dfhe_pkg::KIND_NONE, 8'd0, 9'd0, 16'd0);
		send_token(dfhe_pkg::KIND_END, 8'd0, 9'd0, 16'd0);
		send_token(dfhe_pkg::KIND_END, 8'd0, 9'd0, 16'd0);
		send_token(dfhe_pkg::KIND_NONE, 8'd0, 9'd0, 16'd0);
		send_token(dfhe_pkg::KIND_LITERAL, 8'h5A, 9'd0, 16'd0);
		send_token(dfhe_pkg::KIND_END, 8'd0, 9'd0, 16'd0);

		random_blocks(100);
		write_capacity(21'd0);
		random_blocks(20);
		write_capacity(21'd1);
		random_blocks(15);
		write_capacity(21'd7);
		random_blocks(30);
		write_capacity(21'h1FFFFF);
		random_blocks(30);
		write_capacity(dfhe_pkg::CAP_RESET);
		random_blocks(25);

		wait_drained();
		repeat (32) @(negedge clk);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
